### design/adc_ladder_key_debouncer_core_assert.svh
// Assertion macros shared by the keypad scanner modules.
// Expects clk and rst (active high) to be visible in the module that uses them.
`ifndef ADC_LADDER_KEY_DEBOUNCER_CORE_ASSERT_SVH
`define ADC_LADDER_KEY_DEBOUNCER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define KLD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset
`define KLD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/kld_pkg.sv
// Shared types and constants of the ADC ladder keypad scanner.
// No dependencies; imported by every module of the block but kld_queue.
`default_nettype none

package kld_pkg;

  // Field widths
  localparam int CHAN_W       = 3;
  localparam int SAMPLE_W     = 10;
  localparam int INDEX_W      = 4;
  localparam int CODE_W       = 10;
  localparam int PAIR_W       = 2 * CODE_W;
  localparam int KIND_W       = 2;
  localparam int PERIOD_W     = 6;
  localparam int COUNT_W      = 10;
  localparam int KEY_COUNT_W  = 5;
  localparam int TICKS_W      = 10;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 10;

  // Sizing defaults and fixed limits
  localparam int MAX_KEYS_DFLT = 16;
  localparam int NUM_CHANNELS  = 8;
  localparam int TOK_DEPTH     = 2;
  localparam int RES_DEPTH     = 4;

  // Debounce timing
  localparam logic [PERIOD_W-1:0] PERIOD_DOWN  = PERIOD_W'(10);
  localparam logic [PERIOD_W-1:0] PERIOD_UP    = PERIOD_W'(50);
  localparam logic [COUNT_W-1:0]  JITTER_POLLS = COUNT_W'(3);
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = COUNT_W'(1023);

  // Reset values of the configuration registers
  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RST  = '0;
  localparam logic [TICKS_W-1:0]     LONG_TICKS_RST = TICKS_W'(100);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_COUNT  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_TICKS = CFG_INDEX_W'(1);

  // Event kinds
  localparam logic [KIND_W-1:0] EV_NONE    = KIND_W'(0);
  localparam logic [KIND_W-1:0] EV_PRESS   = KIND_W'(1);
  localparam logic [KIND_W-1:0] EV_RELEASE = KIND_W'(2);

  // Item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    MODE_UP   = 2'd0,
    MODE_DOWN = 2'd1,
    MODE_LONG = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    F_IDLE  = 2'd0,
    F_SCAN  = 2'd1,
    F_CLOSE = 2'd2
  } front_state_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_REL  = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] center;
    logic [SAMPLE_W-1:0] tol;
    logic [CODE_W-1:0]   tap_code;
    logic [CODE_W-1:0]   hold_code;
  } key_entry_t;

  typedef struct packed {
    logic                func;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_ok;
    logic                last_sample;
    logic [INDEX_W-1:0]  entry_index;
    key_entry_t          entry;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CODE_W-1:0]   code;
    logic [PERIOD_W-1:0] period;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

### design/adc_ladder_key_debouncer_core.sv
// Top level of the ADC ladder keypad scanner: configuration registers, front, back, queues.
// Depends on kld_pkg, kld_queue, kld_front and kld_back.
//
//   port group     direction  handshake          beat
//   input items    in         push / full        func, channel, sample, ..., entry_long_code
//   results        out        pop / empty        event_kind, event_code, next_poll_ms, last_of_run
//   configuration  in         cfg_we             cfg_index, cfg_data
//
// A load item writes the key table and leaves the front idle. A sample item that scans
// holds the front until a hit or the last enabled entry, then closes the poll if it is last;
// the scan reads one key table entry per cycle. A sample that does not scan closes the poll if last.
// Reset is synchronous; the key table itself is not cleared and must be loaded before use.
// A closed poll waits in a two-entry queue, and results in a four-entry queue, so a stalled
// result side holds the back while the front keeps taking items until the token queue fills.
`default_nettype none

module adc_ladder_key_debouncer_core #(
  parameter int MAX_KEYS = kld_pkg::MAX_KEYS_DFLT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                func,
  input  logic [kld_pkg::CHAN_W-1:0]          channel,
  input  logic [kld_pkg::SAMPLE_W-1:0]        sample,
  input  logic                                sample_ok,
  input  logic                                last_sample,
  input  logic [kld_pkg::INDEX_W-1:0]         entry_index,
  input  logic [kld_pkg::CHAN_W-1:0]          entry_channel,
  input  logic [kld_pkg::SAMPLE_W-1:0]        entry_center,
  input  logic [kld_pkg::SAMPLE_W-1:0]        entry_tolerance,
  input  logic [kld_pkg::CODE_W-1:0]          entry_short_code,
  input  logic [kld_pkg::CODE_W-1:0]          entry_long_code,
  output logic                                empty,
  input  logic                                pop,
  output logic [kld_pkg::KIND_W-1:0]          event_kind,
  output logic [kld_pkg::CODE_W-1:0]          event_code,
  output logic [kld_pkg::PERIOD_W-1:0]        next_poll_ms,
  output logic                                last_of_run,
  input  logic                                cfg_we,
  input  logic [kld_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [kld_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import kld_pkg::*;

  localparam int RES_W = $bits(result_t);

  logic [KEY_COUNT_W-1:0] key_count;
  logic [TICKS_W-1:0]     long_press_ticks;
  item_t                  item;
  logic                   tok_push;
  logic                   tok_full;
  logic [PAIR_W-1:0]      tok_code_in;
  logic                   tok_pop;
  logic                   tok_empty;
  logic [PAIR_W-1:0]      tok_code_out;
  logic                   res_push;
  logic                   res_full;
  result_t                res_in;
  logic [RES_W-1:0]       res_bits;
  result_t                res_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count        <= KEY_COUNT_RST;
      long_press_ticks <= LONG_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_COUNT:  key_count        <= cfg_data[KEY_COUNT_W-1:0];
        REG_LONG_TICKS: long_press_ticks <= cfg_data[TICKS_W-1:0];
        default: begin
          key_count <= key_count;
        end
      endcase
    end
  end

  // Bundle the item fields
  assign item.func              = func;
  assign item.channel           = channel;
  assign item.sample            = sample;
  assign item.sample_ok         = sample_ok;
  assign item.last_sample       = last_sample;
  assign item.entry_index       = entry_index;
  assign item.entry.chan        = entry_channel;
  assign item.entry.center      = entry_center;
  assign item.entry.tol         = entry_tolerance;
  assign item.entry.tap_code    = entry_short_code;
  assign item.entry.hold_code   = entry_long_code;

  kld_front #(
    .MAX_KEYS (MAX_KEYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .key_count (key_count),
    .tok_push  (tok_push),
    .tok_full  (tok_full),
    .tok_code  (tok_code_in)
  );

  kld_queue #(
    .WIDTH (PAIR_W),
    .DEPTH (TOK_DEPTH)
  ) u_tok_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (tok_push),
    .din   (tok_code_in),
    .full  (tok_full),
    .pop   (tok_pop),
    .dout  (tok_code_out),
    .empty (tok_empty)
  );

  kld_back u_back (
    .clk              (clk),
    .rst              (rst),
    .tok_empty        (tok_empty),
    .tok_pop          (tok_pop),
    .tok_code         (tok_code_out),
    .long_press_ticks (long_press_ticks),
    .res_push         (res_push),
    .res_full         (res_full),
    .res              (res_in)
  );

  kld_queue #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_bits),
    .empty (empty)
  );

  // Unpack the oldest result onto the ports
  assign res_out      = result_t'(res_bits);
  assign event_kind   = res_out.kind;
  assign event_code   = res_out.code;
  assign next_poll_ms = res_out.period;
  assign last_of_run  = res_out.last;

endmodule

`default_nettype wire

### design/kld_queue.sv
// Small synchronous FIFO used between the front, the back and the result port.
// Depends on nothing but its parameters; DEPTH must be a power of two.
`default_nettype none

module kld_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/kld_front.sv
// Front end: takes items, loads the key table and scans it for valid samples until a poll has a hit.
// Depends on kld_pkg and the assertion macro header.
`default_nettype none
`include "adc_ladder_key_debouncer_core_assert.svh"

module kld_front #(
  parameter int MAX_KEYS = kld_pkg::MAX_KEYS_DFLT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  kld_pkg::item_t                     item,
  input  logic [kld_pkg::KEY_COUNT_W-1:0]    key_count,
  output logic                               tok_push,
  input  logic                               tok_full,
  output logic [kld_pkg::PAIR_W-1:0]         tok_code
);

  import kld_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int XW = (CW > KEY_COUNT_W) ? CW : KEY_COUNT_W;
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int NW = $clog2(NUM_CHANNELS + 1) + CHAN_W;

  front_state_t        state, state_next;
  logic [CW-1:0]       scan_addr, scan_addr_next;
  logic                cmp_valid, cmp_valid_next;
  logic                cmp_last, cmp_last_next;
  logic                found, found_next;
  logic [PAIR_W-1:0]   match, match_next;
  logic [CHAN_W-1:0]   s_chan, s_chan_next;
  logic [SAMPLE_W-1:0] s_value, s_value_next;
  logic                s_last, s_last_next;

  key_entry_t          key_mem [MAX_KEYS];
  key_entry_t          entry_q;
  logic                rd_en;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [IW-1:0]       idx_ext;
  logic [XW-1:0]       kc_ext;
  logic [CW-1:0]       n_keys;
  logic                chan_ok;
  logic                accept;
  logic                hit;
  logic [SAMPLE_W:0]   hi_bound;
  logic [SAMPLE_W:0]   v_plus_tol;

  assign accept = push && !full;
  assign full   = (state != F_IDLE);

  // Clamp the searched entry count to the table depth
  assign kc_ext = XW'(key_count);
  assign n_keys = (kc_ext > XW'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(kc_ext);

  // Decode a table load
  assign idx_ext = IW'(item.entry_index);
  assign wr_addr = idx_ext[AW-1:0];
  assign wr_en   = accept && (item.func == FUNC_LOAD) && (idx_ext < IW'(MAX_KEYS));

  assign chan_ok = (NW'(item.channel) < NW'(NUM_CHANNELS));

  // Compare the entry read last cycle against the held sample
  assign hi_bound   = {1'b0, entry_q.center} + {1'b0, entry_q.tol};
  assign v_plus_tol = {1'b0, s_value} + {1'b0, entry_q.tol};
  assign hit = (entry_q.chan == s_chan) &&
               ({1'b0, s_value} <= hi_bound) &&
               (v_plus_tol >= {1'b0, entry_q.center});

  assign tok_code = match;

  // Key table: one write port for loads, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= item.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      entry_q <= key_mem[scan_addr[AW-1:0]];
    end
  end

  // Control and poll state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      scan_addr <= '0;
      cmp_valid <= 1'b0;
      cmp_last  <= 1'b0;
      found     <= 1'b0;
      match     <= '0;
    end else begin
      state     <= state_next;
      scan_addr <= scan_addr_next;
      cmp_valid <= cmp_valid_next;
      cmp_last  <= cmp_last_next;
      found     <= found_next;
      match     <= match_next;
    end
  end

  // Held sample of the item being scanned
  always_ff @(posedge clk) begin
    s_chan  <= s_chan_next;
    s_value <= s_value_next;
    s_last  <= s_last_next;
  end

  // Next state: accept, scan one entry per cycle, then hand the poll to the back
  always_comb begin
    state_next     = state;
    scan_addr_next = scan_addr;
    cmp_valid_next = cmp_valid;
    cmp_last_next  = cmp_last;
    found_next     = found;
    match_next     = match;
    s_chan_next    = s_chan;
    s_value_next   = s_value;
    s_last_next    = s_last;
    rd_en          = 1'b0;
    tok_push       = 1'b0;
    case (state)
      F_IDLE: begin
        cmp_valid_next = 1'b0;
        cmp_last_next  = 1'b0;
        scan_addr_next = '0;
        if (accept && (item.func == FUNC_SAMPLE)) begin
          s_chan_next  = item.channel;
          s_value_next = item.sample;
          s_last_next  = item.last_sample;
          if (item.sample_ok && chan_ok && !found && (n_keys != '0)) begin
            state_next = F_SCAN;
          end else if (item.last_sample) begin
            state_next = F_CLOSE;
          end
        end
      end
      F_SCAN: begin
        if (cmp_valid && hit) begin
          found_next = 1'b1;
          match_next = {entry_q.hold_code, entry_q.tap_code};
          state_next = s_last ? F_CLOSE : F_IDLE;
        end else if (cmp_valid && cmp_last) begin
          state_next = s_last ? F_CLOSE : F_IDLE;
        end else begin
          rd_en          = 1'b1;
          cmp_valid_next = 1'b1;
          cmp_last_next  = (scan_addr == n_keys - 1'b1);
          scan_addr_next = scan_addr + 1'b1;
        end
      end
      F_CLOSE: begin
        if (!tok_full) begin
          tok_push   = 1'b1;
          found_next = 1'b0;
          match_next = '0;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  `KLD_ASSERT_IMP(a_tok_only_close, tok_push, state == F_CLOSE, "front: token outside close")
  `KLD_ASSERT_IMP(a_scan_bound, state == F_SCAN, scan_addr <= n_keys, "front: scan overran table")
  `KLD_ASSERT_NXT(a_found_holds, found && state != F_CLOSE, found, "front: match lost in poll")

endmodule

`default_nettype wire

### design/kld_back.sv
// Back end: steps the debounce machine once per closed poll and emits results.
// Depends on kld_pkg and the assertion macro header.
`default_nettype none
`include "adc_ladder_key_debouncer_core_assert.svh"

module kld_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tok_empty,
  output logic                            tok_pop,
  input  logic [kld_pkg::PAIR_W-1:0]      tok_code,
  input  logic [kld_pkg::TICKS_W-1:0]     long_press_ticks,
  output logic                            res_push,
  input  logic                            res_full,
  output kld_pkg::result_t                res
);

  import kld_pkg::*;

  back_state_t          bstate, bstate_next;
  mode_t                mode, mode_next;
  logic [COUNT_W-1:0]   down_polls, down_polls_next;
  logic [COUNT_W-1:0]   up_polls, up_polls_next;
  logic [PERIOD_W-1:0]  period, period_next;
  logic [PAIR_W-1:0]    held, held_next;

  logic [CODE_W-1:0]    short_part;
  logic [CODE_W-1:0]    long_part;

  assign short_part = tok_code[CODE_W-1:0];
  assign long_part  = tok_code[PAIR_W-1:CODE_W];

  // Debounce state
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate     <= B_IDLE;
      mode       <= MODE_UP;
      down_polls <= '0;
      up_polls   <= '0;
      period     <= PERIOD_UP;
      held       <= '0;
    end else begin
      bstate     <= bstate_next;
      mode       <= mode_next;
      down_polls <= down_polls_next;
      up_polls   <= up_polls_next;
      period     <= period_next;
      held       <= held_next;
    end
  end

  // Step on a closed poll; a late short press takes a second beat for its release
  always_comb begin
    bstate_next     = bstate;
    mode_next       = mode;
    down_polls_next = down_polls;
    up_polls_next   = up_polls;
    period_next     = period;
    held_next       = held;
    tok_pop         = 1'b0;
    res_push        = 1'b0;
    res             = '{kind: EV_NONE, code: '0, period: period, last: 1'b1};
    case (bstate)
      B_IDLE: begin
        if (!tok_empty && !res_full) begin
          tok_pop  = 1'b1;
          res_push = 1'b1;
          // Count down or up polls and track the poll period
          if (tok_code != '0) begin
            period_next     = PERIOD_DOWN;
            down_polls_next = (down_polls != COUNT_MAX) ? down_polls + 1'b1 : down_polls;
            up_polls_next   = '0;
          end else begin
            up_polls_next   = (up_polls != COUNT_MAX) ? up_polls + 1'b1 : up_polls;
            down_polls_next = '0;
            period_next     = (period < PERIOD_UP) ? period + 1'b1 : period;
          end
          res.period = period_next;
          case (mode)
            MODE_UP: begin
              if (down_polls_next >= JITTER_POLLS) begin
                if (long_part != '0) begin
                  held_next = tok_code;
                  mode_next = MODE_LONG;
                end else begin
                  held_next = PAIR_W'(short_part);
                  res.kind  = EV_PRESS;
                  res.code  = short_part;
                  mode_next = MODE_DOWN;
                end
              end
            end
            MODE_DOWN: begin
              if (up_polls_next >= JITTER_POLLS) begin
                res.kind  = EV_RELEASE;
                res.code  = held[CODE_W-1:0];
                mode_next = MODE_UP;
              end
            end
            MODE_LONG: begin
              if (down_polls_next >= long_press_ticks) begin
                held_next = PAIR_W'(held[PAIR_W-1:CODE_W]);
                res.kind  = EV_PRESS;
                res.code  = held[PAIR_W-1:CODE_W];
                mode_next = MODE_DOWN;
              end else if (up_polls_next >= JITTER_POLLS) begin
                held_next   = PAIR_W'(held[CODE_W-1:0]);
                res.kind    = EV_PRESS;
                res.code    = held[CODE_W-1:0];
                res.last    = 1'b0;
                mode_next   = MODE_UP;
                bstate_next = B_REL;
              end
            end
            default: begin
              mode_next = mode;
            end
          endcase
        end
      end
      B_REL: begin
        res.kind = EV_RELEASE;
        res.code = held[CODE_W-1:0];
        if (!res_full) begin
          res_push    = 1'b1;
          bstate_next = B_IDLE;
        end
      end
      default: begin
        bstate_next = B_IDLE;
      end
    endcase
  end

  `KLD_ASSERT_IMP(a_counts_exclusive, down_polls != '0, up_polls == '0, "back: both counters run")
  `KLD_ASSERT_IMP(a_period_range, 1'b1, period >= PERIOD_DOWN && period <= PERIOD_UP, "back: period out of range")
  `KLD_ASSERT_IMP(a_rel_mode_up, bstate == B_REL, mode == MODE_UP, "back: release pending while not up")

endmodule

`default_nettype wire

### verif/adc_ladder_key_debouncer_core_tb.sv
// Self-checking testbench for the ADC ladder keypad scanner core.
// Depends on kld_pkg and adc_ladder_key_debouncer_core; predicts every event beat in-bench.
`default_nettype none

module adc_ladder_key_debouncer_core_tb;
  import kld_pkg::*;

  localparam int TABLE_DEPTH = MAX_KEYS_DFLT;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 75;
  localparam int ITEM_W      = $bits(item_t);

  // Clock, reset and block ports
  logic                   clk              = 1'b0;
  logic                   rst              = 1'b1;
  logic                   push             = 1'b0;
  logic                   full;
  logic                   func             = 1'b0;
  logic [CHAN_W-1:0]      channel          = '0;
  logic [SAMPLE_W-1:0]    sample           = '0;
  logic                   sample_ok        = 1'b0;
  logic                   last_sample      = 1'b0;
  logic [INDEX_W-1:0]     entry_index      = '0;
  logic [CHAN_W-1:0]      entry_channel    = '0;
  logic [SAMPLE_W-1:0]    entry_center     = '0;
  logic [SAMPLE_W-1:0]    entry_tolerance  = '0;
  logic [CODE_W-1:0]      entry_short_code = '0;
  logic [CODE_W-1:0]      entry_long_code  = '0;
  logic                   empty;
  logic                   pop              = 1'b0;
  logic [KIND_W-1:0]      event_kind;
  logic [CODE_W-1:0]      event_code;
  logic [PERIOD_W-1:0]    next_poll_ms;
  logic                   last_of_run;
  logic                   cfg_we           = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index        = '0;
  logic [CFG_DATA_W-1:0]  cfg_data         = '0;

  // Scanner model state
  key_entry_t        key_rows [TABLE_DEPTH];
  int unsigned       keys_enabled;
  int unsigned       long_ticks;
  logic [PAIR_W-1:0] poll_pair;
  bit                poll_hit;
  mode_t             key_mode;
  int unsigned       down_run;
  int unsigned       up_run;
  logic [PERIOD_W-1:0] period_ms;
  logic [PAIR_W-1:0] held_pair;
  result_t           expected_events [$];

  // Stimulus side: table layout as the queued loads leave it, and the item backlog
  key_entry_t  plan_rows [TABLE_DEPTH];
  item_t       item_backlog [$];
  item_t       drv_item;
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned errors         = 0;

  // Idle draws of both sides
  int unsigned in_wait  = 0;
  int unsigned in_run   = 0;
  bit          in_calm  = 1'b0;
  int unsigned out_wait = 0;
  int unsigned out_run  = 0;
  bit          out_calm = 1'b0;
  result_t     want;

  adc_ladder_key_debouncer_core dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .func             (func),
    .channel          (channel),
    .sample           (sample),
    .sample_ok        (sample_ok),
    .last_sample      (last_sample),
    .entry_index      (entry_index),
    .entry_channel    (entry_channel),
    .entry_center     (entry_center),
    .entry_tolerance  (entry_tolerance),
    .entry_short_code (entry_short_code),
    .entry_long_code  (entry_long_code),
    .empty            (empty),
    .pop              (pop),
    .event_kind       (event_kind),
    .event_code       (event_code),
    .next_poll_ms     (next_poll_ms),
    .last_of_run      (last_of_run),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  // Draw an idle count; alternate between calm stretches and stretches with gaps
  function automatic int unsigned draw_wait(inout int unsigned run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 2) == 0);
      run_left = $urandom_range(5, 40);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic result_t make_event(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code);
    result_t ev;
    ev.kind   = kind;
    ev.code   = code;
    ev.period = period_ms;
    ev.last   = 1'b0;
    return ev;
  endfunction

  // Apply one accepted item to the model; a poll close queues its events
  function automatic void advance_scanner(item_t it);
    int                lo;
    int                hi;
    int unsigned       n;
    int unsigned       j;
    logic [PAIR_W-1:0] pair;
    result_t           evs [$];
    if (it.func == FUNC_LOAD) begin
      if (it.entry_index < TABLE_DEPTH) key_rows[it.entry_index] = it.entry;
      return;
    end
    // remember the first row hit in this poll, table order within a sample
    if (it.sample_ok && !poll_hit && it.channel < NUM_CHANNELS) begin
      n = (keys_enabled > TABLE_DEPTH) ? TABLE_DEPTH : keys_enabled;
      for (j = 0; j < n && !poll_hit; j++) begin
        lo = int'(key_rows[j].center) - int'(key_rows[j].tol);
        hi = int'(key_rows[j].center) + int'(key_rows[j].tol);
        if (key_rows[j].chan == it.channel && int'(it.sample) >= lo &&
            int'(it.sample) <= hi) begin
          poll_hit  = 1'b1;
          poll_pair = {key_rows[j].hold_code, key_rows[j].tap_code};
        end
      end
    end
    if (!it.last_sample) return;

    // update run counters and poll period
    pair = poll_hit ? poll_pair : '0;
    if (pair != '0) begin
      period_ms = PERIOD_DOWN;
      if (down_run < COUNT_MAX) down_run++;
      up_run = 0;
    end else begin
      if (up_run < COUNT_MAX) up_run++;
      down_run = 0;
      if (period_ms < PERIOD_UP) period_ms++;
    end

    // step the debounce machine
    case (key_mode)
      MODE_UP: begin
        if (down_run >= JITTER_POLLS) begin
          if (pair[PAIR_W-1:CODE_W] != '0) begin
            held_pair = pair;
            key_mode  = MODE_LONG;
          end else begin
            held_pair = {{CODE_W{1'b0}}, pair[CODE_W-1:0]};
            evs.push_back(make_event(EV_PRESS, held_pair[CODE_W-1:0]));
            key_mode = MODE_DOWN;
          end
        end
      end
      MODE_DOWN: begin
        if (up_run >= JITTER_POLLS) begin
          evs.push_back(make_event(EV_RELEASE, held_pair[CODE_W-1:0]));
          key_mode = MODE_UP;
        end
      end
      MODE_LONG: begin
        if (down_run >= long_ticks) begin
          held_pair = {{CODE_W{1'b0}}, held_pair[PAIR_W-1:CODE_W]};
          evs.push_back(make_event(EV_PRESS, held_pair[CODE_W-1:0]));
          key_mode = MODE_DOWN;
        end else if (up_run >= JITTER_POLLS) begin
          held_pair = {{CODE_W{1'b0}}, held_pair[CODE_W-1:0]};
          evs.push_back(make_event(EV_PRESS, held_pair[CODE_W-1:0]));
          evs.push_back(make_event(EV_RELEASE, held_pair[CODE_W-1:0]));
          key_mode = MODE_UP;
        end
      end
      default: begin
      end
    endcase

    if (evs.size() == 0) evs.push_back(make_event(EV_NONE, '0));
    evs[evs.size() - 1].last = 1'b1;
    foreach (evs[k]) expected_events.push_back(evs[k]);
    poll_hit  = 1'b0;
    poll_pair = '0;
  endfunction

  // Stimulus builders
  function automatic item_t blank_item();
    logic [ITEM_W-1:0] raw;
    raw = ITEM_W'({$urandom, $urandom});
    return item_t'(raw);
  endfunction

  function automatic void queue_item(item_t it);
    item_backlog.push_back(it);
    items_queued++;
  endfunction

  function automatic key_entry_t key_row(int unsigned ch, int unsigned center,
                                         int unsigned tol, int unsigned tap,
                                         int unsigned hold);
    key_entry_t r;
    r.chan      = CHAN_W'(ch);
    r.center    = SAMPLE_W'(center);
    r.tol       = SAMPLE_W'(tol);
    r.tap_code  = CODE_W'(tap);
    r.hold_code = CODE_W'(hold);
    return r;
  endfunction

  function automatic key_entry_t random_row();
    key_entry_t  r;
    int unsigned pick;
    pick     = $urandom_range(0, 9);
    r.chan   = CHAN_W'($urandom);
    r.center = SAMPLE_W'($urandom);
    if (pick < 6) r.tol = SAMPLE_W'($urandom_range(0, 30));
    else if (pick < 9) r.tol = SAMPLE_W'($urandom_range(0, 200));
    else r.tol = SAMPLE_W'($urandom);
    pick        = $urandom_range(0, 9);
    r.tap_code  = CODE_W'($urandom_range(0, 767));
    r.hold_code = (pick < 4) ? CODE_W'($urandom_range(1, 767)) : '0;
    if (pick == 9) begin
      r.tap_code  = '0;
      r.hold_code = '0;
    end
    return r;
  endfunction

  function automatic void load_key(int unsigned idx, key_entry_t r);
    item_t it;
    it             = blank_item();
    it.func        = FUNC_LOAD;
    it.entry_index = INDEX_W'(idx);
    it.entry       = r;
    plan_rows[idx] = r;
    queue_item(it);
  endfunction

  function automatic void adc_read(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] val,
                                   logic ok, logic close);
    item_t it;
    it             = blank_item();
    it.func        = FUNC_SAMPLE;
    it.channel     = ch;
    it.sample      = val;
    it.sample_ok   = ok;
    it.last_sample = close;
    queue_item(it);
  endfunction

  // One poll of count samples, or 1..3 when count is zero; a key index >= 0 puts a reading inside that row's window
  function automatic void poll(int key, int unsigned count);
    int unsigned n;
    int unsigned at;
    int unsigned s;
    int unsigned c;
    int unsigned t;
    int unsigned lo;
    int unsigned hi;
    n  = (count == 0) ? $urandom_range(1, 3) : count;
    at = $urandom_range(0, n - 1);
    for (s = 0; s < n; s++) begin
      if (key >= 0 && s == at) begin
        c  = plan_rows[key].center;
        t  = plan_rows[key].tol;
        lo = (c > t) ? c - t : 0;
        hi = (c + t > 1023) ? 1023 : c + t;
        adc_read(plan_rows[key].chan, SAMPLE_W'($urandom_range(hi, lo)), 1'b1, s == n - 1);
      end else begin
        adc_read(CHAN_W'($urandom), SAMPLE_W'($urandom), 1'($urandom_range(0, 1)),
                 s == n - 1);
      end
    end
  endfunction

  // Hold a key for a jitter, short or long run of polls, then let it go
  function automatic void press_run();
    int          key;
    int unsigned n;
    int unsigned pick;
    int unsigned hold;
    n    = (keys_enabled > TABLE_DEPTH) ? TABLE_DEPTH : keys_enabled;
    key  = (n == 0) ? -1 : int'($urandom_range(n - 1, 0));
    pick = $urandom_range(0, 9);
    if (pick < 2) hold = $urandom_range(1, 2);
    else if (pick < 7 || long_ticks > 30) hold = $urandom_range(3, 8);
    else hold = ((long_ticks > 4) ? long_ticks : 4) + $urandom_range(0, 2);
    repeat (hold) poll(key, 0);
    repeat ($urandom_range(1, 5)) poll(-1, 0);
  endfunction

  // Write one register while the block is idle; mirror it into the model
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    if (idx == REG_KEY_COUNT) keys_enabled = val % (1 << KEY_COUNT_W);
    else long_ticks = val % (1 << TICKS_W);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item is taken and every event beat is back, then let the block drain
  task automatic settle();
    @(posedge clk);
    while (items_accepted != items_queued || expected_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Driver: present backlog items, predict each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        advance_scanner(drv_item);
        items_accepted++;
      end
      if (!push || !full) begin
        if (in_wait > 0) begin
          in_wait--;
          push <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          drv_item = item_backlog.pop_front();
          func             <= drv_item.func;
          channel          <= drv_item.channel;
          sample           <= drv_item.sample;
          sample_ok        <= drv_item.sample_ok;
          last_sample      <= drv_item.last_sample;
          entry_index      <= drv_item.entry_index;
          entry_channel    <= drv_item.entry.chan;
          entry_center     <= drv_item.entry.center;
          entry_tolerance  <= drv_item.entry.tol;
          entry_short_code <= drv_item.entry.tap_code;
          entry_long_code  <= drv_item.entry.hold_code;
          push             <= 1'b1;
          in_wait = draw_wait(in_run, in_calm);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] got);
    if (got !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got);
      errors++;
    end
  endfunction

  // Monitor: take event beats with random stalls, compare against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          $error("event_kind: expected no beat, got %0d (event_code %0d)",
                 event_kind, event_code);
          errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 16'(want.kind), 16'(event_kind));
          check_field("event_code", 16'(want.code), 16'(event_code));
          check_field("next_poll_ms", 16'(want.period), 16'(next_poll_ms));
          check_field("last_of_run", 16'(want.last), 16'(last_of_run));
        end
        out_wait = draw_wait(out_run, out_calm);
      end
      if (out_wait > 0) begin
        out_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    int unsigned kc_plan    [PHASES];
    int unsigned ticks_plan [PHASES];
    int unsigned ph;
    int unsigned mark;
    int unsigned pick;
    kc_plan    = '{16, 31, 1, 9, 16};
    ticks_plan = '{1, 0, 1023, 7, 3};

    keys_enabled = KEY_COUNT_RST;
    long_ticks   = LONG_TICKS_RST;
    poll_hit     = 1'b0;
    poll_pair    = '0;
    key_mode     = MODE_UP;
    down_run     = 0;
    up_run       = 0;
    period_ms    = PERIOD_UP;
    held_pair    = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: load a small table, poll with an empty search range
    load_key(0, key_row(0, 0, 0, 767, 0));
    load_key(1, key_row(7, 1023, 1023, 1, 767));
    load_key(2, key_row(3, 500, 20, 0, 0));
    load_key(3, key_row(3, 530, 5, 300, 0));
    load_key(4, key_row(5, 200, 10, 0, 512));
    load_key(5, key_row(5, 200, 10, 5, 10));
    load_key(15, key_row(2, 100, 3, 42, 0));
    adc_read(3'd0, 10'd0, 1'b1, 1'b1);
    adc_read(3'd7, 10'd1023, 1'b0, 1'b1);
    settle();

    write_reg(REG_KEY_COUNT, 6);
    write_reg(REG_LONG_TICKS, 4);
    // short press at the window floor, released by failed conversions
    repeat (3) adc_read(3'd0, 10'd0, 1'b1, 1'b1);
    repeat (3) adc_read(3'd0, 10'd0, 1'b0, 1'b1);
    // long press on the widest window
    repeat (4) adc_read(3'd7, 10'd1023, 1'b1, 1'b1);
    // a code-less row hit first masks later hits; then window edges release the key
    adc_read(3'd3, 10'd500, 1'b1, 1'b0);
    adc_read(3'd7, 10'd5, 1'b1, 1'b0);
    adc_read(3'd0, 10'd0, 1'b1, 1'b1);
    adc_read(3'd3, 10'd521, 1'b1, 1'b1);
    adc_read(3'd3, 10'd520, 1'b1, 1'b1);
    // long-only key let go early: press and release of the short code
    repeat (3) adc_read(3'd5, 10'd190, 1'b1, 1'b1);
    repeat (3) adc_read(3'd2, 10'd0, 1'b0, 1'b1);
    // fill the whole table with random rows
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) load_key(i, random_row());
    poll(-1, 1);
    settle();

    // Random phases over a spread of settings
    for (ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_KEY_COUNT, kc_plan[ph]);
      write_reg(REG_LONG_TICKS, ticks_plan[ph]);
      mark = items_queued;
      while (items_queued - mark < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) press_run();
        else if (pick < 17) load_key($urandom_range(0, TABLE_DEPTH - 1), random_row());
        else poll(-1, 0);
      end
      poll(-1, 1);
      settle();
    end

    if (errors == 0) begin
      $display("adc_ladder_key_debouncer_core_tb: PASS");
    end else begin
      $display("adc_ladder_key_debouncer_core_tb: FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20_000_000;
    $display("adc_ladder_key_debouncer_core_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+design
design/kld_pkg.sv
design/kld_queue.sv
design/kld_front.sv
design/kld_back.sv
design/adc_ladder_key_debouncer_core.sv
verif/adc_ladder_key_debouncer_core_tb.sv
